/* rtl/tsrd_pkg.sv */
package tsrd_pkg;

    localparam int FINGERS    = 5;
    localparam int FIDX_W     = 3;
    localparam int FORCE_BITS = 16;
    localparam int THR_BITS   = 12;
    localparam int THR_ALL_W  = FINGERS * THR_BITS;
    localparam int PADDR_W    = 6;
    localparam int PDATA_W    = 64;

    typedef logic signed [FORCE_BITS-1:0] force_t;
    typedef logic [THR_BITS-1:0]          thr_t;
    typedef logic [FIDX_W-1:0]            fidx_t;
    typedef logic [1:0]                   alu_op_t;
    typedef logic [2:0]                   reg_idx_t;

    typedef struct packed {
        thr_t contact;
        thr_t delta;
        thr_t spread;
    } thr_set_t;

    // shared unit operations
    localparam alu_op_t ALU_NOP   = 2'd0;
    localparam alu_op_t ALU_LOAD  = 2'd1;
    localparam alu_op_t ALU_ACC   = 2'd2;
    localparam alu_op_t ALU_SCALE = 2'd3;

    localparam logic ACT_FORCE = 1'b0;
    localparam logic ACT_STATE = 1'b1;

    localparam logic [2:0] MODE_HOLD_A = 3'd1;
    localparam logic [2:0] MODE_HOLD_B = 3'd2;
    localparam logic [2:0] MODE_OFF    = 3'd3;

    localparam logic [1:0] ST_EVAL       = 2'd0;
    localparam logic [1:0] ST_SUPPRESSED = 2'd1;
    localparam logic [1:0] ST_SKIPPED    = 2'd2;
    localparam logic [1:0] ST_UPDATE     = 2'd3;

    localparam reg_idx_t REG_WINDOW_LENGTH = 3'd0;
    localparam reg_idx_t REG_STARTUP       = 3'd1;
    localparam reg_idx_t REG_COOLDOWN      = 3'd2;
    localparam reg_idx_t REG_POST_GRASP    = 3'd3;
    localparam reg_idx_t REG_CONTACT_THR   = 3'd4;
    localparam reg_idx_t REG_DELTA_THR     = 3'd5;
    localparam reg_idx_t REG_SPREAD_THR    = 3'd6;

    localparam logic [THR_ALL_W-1:0] CONTACT_THR_RST = 60'h050050050050050;
    localparam logic [THR_ALL_W-1:0] DELTA_THR_RST   = 60'h140140140140140;
    localparam logic [THR_ALL_W-1:0] SPREAD_THR_RST  = 60'h050050050050050;

endpackage

/* rtl/tsrd_window_mem.sv */
module tsrd_window_mem #(
    parameter int WINDOW_MAX = 8,
    localparam int HEAD_W = $clog2(WINDOW_MAX)
) (
    input  logic                 clk,
    input  tsrd_pkg::fidx_t      finger,
    input  logic                 wr_en,
    input  logic [HEAD_W-1:0]    wr_idx,
    input  tsrd_pkg::force_t     wr_data,
    input  logic                 rd_en,
    input  logic [HEAD_W-1:0]    rd_idx,
    output tsrd_pkg::force_t     rd_data
);
    import tsrd_pkg::*;

    force_t mem [FINGERS][WINDOW_MAX];
    force_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[finger][wr_idx] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[finger][rd_idx];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/tsrd_alu.sv */
module tsrd_alu #(
    parameter int WINDOW_MAX = 8,
    localparam int LEN_W = $clog2(WINDOW_MAX + 1)
) (
    input  logic                 clk,
    input  tsrd_pkg::alu_op_t    op,
    input  logic [LEN_W-1:0]     len,
    input  tsrd_pkg::force_t     x,
    input  tsrd_pkg::thr_set_t   thr,
    output logic                 fire
);
    import tsrd_pkg::*;

    localparam int SUM_W  = FORCE_BITS + LEN_W;
    localparam int PROD_W = FORCE_BITS + LEN_W + 1;
    localparam int DIFF_W = PROD_W + 1;
    localparam int PD_W   = THR_BITS + LEN_W;
    localparam int FW1    = FORCE_BITS + 1;

    force_t                   force_reg, force_next;
    force_t                   lo_reg, lo_next;
    force_t                   hi_reg, hi_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic signed [PROD_W-1:0] prod_f_reg, prod_f_next;
    logic [PD_W-1:0]          prod_d_reg, prod_d_next;

    logic signed [DIFF_W-1:0] mean_diff;
    logic signed [FW1-1:0]    spread;
    logic                     hit_contact;
    logic                     hit_delta;
    logic                     hit_spread;

    always_comb
    begin
        force_next  = force_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        sum_next    = sum_reg;
        prod_f_next = prod_f_reg;
        prod_d_next = prod_d_reg;
        unique case (op)
            ALU_LOAD:
            begin
                // newest sample seeds sum, min and max
                force_next = x;
                lo_next    = x;
                hi_next    = x;
                sum_next   = SUM_W'(x);
            end
            ALU_ACC:
            begin
                sum_next = sum_reg + SUM_W'(x);
                lo_next  = (x < lo_reg) ? x : lo_reg;
                hi_next  = (x > hi_reg) ? x : hi_reg;
            end
            ALU_SCALE:
            begin
                prod_f_next = PROD_W'($signed({1'b0, len})) * PROD_W'(force_reg);
                prod_d_next = PD_W'(len) * PD_W'(thr.delta);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        force_reg  <= force_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        sum_reg    <= sum_next;
        prod_f_reg <= prod_f_next;
        prod_d_reg <= prod_d_next;
    end

    // L*force - sum > L*delta stands in for force - mean > delta
    assign mean_diff   = DIFF_W'(prod_f_reg) - DIFF_W'(sum_reg);
    assign spread      = FW1'(hi_reg) - FW1'(lo_reg);
    assign hit_contact = FW1'(force_reg) > $signed(FW1'({1'b0, thr.contact}));
    assign hit_delta   = mean_diff > $signed(DIFF_W'({1'b0, prod_d_reg}));
    assign hit_spread  = spread > $signed(FW1'({1'b0, thr.spread}));
    assign fire        = hit_contact && hit_delta && hit_spread;

endmodule

/* rtl/tactile_slip_release_detector_unit.sv */
// A state update, a suppressed or a skipped frame goes from idle straight to the done state,
// where the result registers when the output is free. An evaluated frame visits the five
// fingers in turn: one not tested takes only the write state, a tested one goes through write,
// read, scale and check; read takes older samples from the single memory read port, one a cycle.
// Throughput: one request at a time, next taken after the result registers (waits on out_ready).
// Reset (rst_n low, async): registers to defaults, windows empty, memory is not cleared.
module tactile_slip_release_detector_unit #(
    parameter int WINDOW_MAX = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          action,
    input  tsrd_pkg::force_t              force_thumb,
    input  tsrd_pkg::force_t              force_index,
    input  tsrd_pkg::force_t              force_middle,
    input  tsrd_pkg::force_t              force_ring,
    input  tsrd_pkg::force_t              force_little,
    input  logic [2:0]                    new_grasp_state,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [4:0]                    release_mask,
    output logic [1:0]                    status,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tsrd_pkg::PADDR_W-1:0]  paddr,
    input  logic [tsrd_pkg::PDATA_W-1:0]  pwdata,
    output logic [tsrd_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import tsrd_pkg::*;

    localparam int HEAD_W = $clog2(WINDOW_MAX);
    localparam int LEN_W  = $clog2(WINDOW_MAX + 1);
    localparam logic [4:0] WIN_MAX5 = 5'(WINDOW_MAX);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WRITE = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_SCALE = 3'd3;
    localparam logic [2:0] S_CHECK = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [3:0]           window_length_reg, window_length_next;
    logic [15:0]          startup_frames_reg, startup_frames_next;
    logic [7:0]           cooldown_frames_reg, cooldown_frames_next;
    logic [15:0]          post_grasp_frames_reg, post_grasp_frames_next;
    logic [THR_ALL_W-1:0] contact_thr_reg, contact_thr_next;
    logic [THR_ALL_W-1:0] delta_thr_reg, delta_thr_next;
    logic [THR_ALL_W-1:0] spread_thr_reg, spread_thr_next;

    logic [2:0]           grasp_mode_reg, grasp_mode_next;
    logic [15:0]          post_left_reg, post_left_next;
    logic [15:0]          frame_count_reg, frame_count_next;
    logic [LEN_W-1:0]     fill_reg [FINGERS];
    logic [LEN_W-1:0]     fill_next [FINGERS];
    logic [HEAD_W-1:0]    head_reg [FINGERS];
    logic [HEAD_W-1:0]    head_next [FINGERS];
    logic [7:0]           cooldown_reg [FINGERS];
    logic [7:0]           cooldown_next [FINGERS];
    force_t               force_reg [FINGERS];

    logic [2:0]           state_reg, state_next;
    fidx_t                finger_reg, finger_next;
    logic [HEAD_W-1:0]    rd_idx_reg, rd_idx_next;
    logic [LEN_W-1:0]     remain_reg, remain_next;
    logic                 rd_pend_reg, rd_pend_next;
    logic [4:0]           mask_work_reg, mask_work_next;
    logic [1:0]           status_work_reg, status_work_next;
    logic                 out_valid_reg, out_valid_next;
    logic [4:0]           release_mask_reg, release_mask_next;
    logic [1:0]           status_reg, status_next;

    logic [4:0]           len5;
    logic [LEN_W-1:0]     len_eff;
    logic [LEN_W:0]       fill_inc;
    logic [LEN_W-1:0]     fill_new;
    logic [7:0]           cd_new;
    logic [HEAD_W-1:0]    head_cur;
    logic                 last_finger;
    logic                 cfg_wr;
    reg_idx_t             cfg_idx;

    logic                 mem_wr_en;
    logic                 mem_rd_en;
    force_t               mem_rdata;
    alu_op_t              alu_op;
    force_t               alu_x;
    thr_set_t             thr;
    logic                 alu_fire;

    function automatic logic [HEAD_W-1:0] idx_dec(input logic [HEAD_W-1:0] i);
        return (i == '0) ? HEAD_W'(WINDOW_MAX - 1) : i - 1'b1;
    endfunction

    assign len5 = (window_length_reg == '0) ? 5'd1 :
                  (({1'b0, window_length_reg} > WIN_MAX5) ? WIN_MAX5 : {1'b0, window_length_reg});
    assign len_eff = LEN_W'(len5);

    assign head_cur    = head_reg[finger_reg];
    assign fill_inc    = {1'b0, fill_reg[finger_reg]} + 1'b1;
    assign fill_new    = (fill_inc > {1'b0, len_eff}) ? len_eff : fill_inc[LEN_W-1:0];
    assign cd_new      = (cooldown_reg[finger_reg] != '0) ? cooldown_reg[finger_reg] - 1'b1 : '0;
    assign last_finger = (finger_reg == fidx_t'(FINGERS - 1));

    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[PADDR_W-1:3];

    assign thr.contact = contact_thr_reg[THR_BITS*finger_reg +: THR_BITS];
    assign thr.delta   = delta_thr_reg[THR_BITS*finger_reg +: THR_BITS];
    assign thr.spread  = spread_thr_reg[THR_BITS*finger_reg +: THR_BITS];
    assign alu_x       = (state_reg == S_READ) ? mem_rdata : force_reg[finger_reg];

    always_comb
    begin
        window_length_next     = window_length_reg;
        startup_frames_next    = startup_frames_reg;
        cooldown_frames_next   = cooldown_frames_reg;
        post_grasp_frames_next = post_grasp_frames_reg;
        contact_thr_next       = contact_thr_reg;
        delta_thr_next         = delta_thr_reg;
        spread_thr_next        = spread_thr_reg;
        if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_WINDOW_LENGTH: window_length_next     = pwdata[3:0];
                REG_STARTUP:       startup_frames_next    = pwdata[15:0];
                REG_COOLDOWN:      cooldown_frames_next   = pwdata[7:0];
                REG_POST_GRASP:    post_grasp_frames_next = pwdata[15:0];
                REG_CONTACT_THR:   contact_thr_next       = pwdata[THR_ALL_W-1:0];
                REG_DELTA_THR:     delta_thr_next         = pwdata[THR_ALL_W-1:0];
                REG_SPREAD_THR:    spread_thr_next        = pwdata[THR_ALL_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_WINDOW_LENGTH: prdata = PDATA_W'(window_length_reg);
            REG_STARTUP:       prdata = PDATA_W'(startup_frames_reg);
            REG_COOLDOWN:      prdata = PDATA_W'(cooldown_frames_reg);
            REG_POST_GRASP:    prdata = PDATA_W'(post_grasp_frames_reg);
            REG_CONTACT_THR:   prdata = PDATA_W'(contact_thr_reg);
            REG_DELTA_THR:     prdata = PDATA_W'(delta_thr_reg);
            REG_SPREAD_THR:    prdata = PDATA_W'(spread_thr_reg);
            default:           prdata = '0;
        endcase
    end

    always_comb
    begin
        state_next        = state_reg;
        grasp_mode_next   = grasp_mode_reg;
        post_left_next    = post_left_reg;
        frame_count_next  = frame_count_reg;
        fill_next         = fill_reg;
        head_next         = head_reg;
        cooldown_next     = cooldown_reg;
        finger_next       = finger_reg;
        rd_idx_next       = rd_idx_reg;
        remain_next       = remain_reg;
        rd_pend_next      = 1'b0;
        mask_work_next    = mask_work_reg;
        status_work_next  = status_work_reg;
        out_valid_next    = out_valid_reg;
        release_mask_next = release_mask_reg;
        status_next       = status_reg;
        mem_wr_en         = 1'b0;
        mem_rd_en         = 1'b0;
        alu_op            = ALU_NOP;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    mask_work_next = '0;
                    priority if (action == ACT_STATE)
                    begin
                        if (grasp_mode_reg == MODE_HOLD_A && new_grasp_state == MODE_HOLD_B)
                        begin
                            post_left_next = post_grasp_frames_reg;
                        end
                        grasp_mode_next = new_grasp_state;
                        for (int f = 0; f < FINGERS; f++)
                        begin
                            fill_next[f] = '0;
                            head_next[f] = '0;
                        end
                        status_work_next = ST_UPDATE;
                        state_next       = S_DONE;
                    end
                    else if (grasp_mode_reg == MODE_HOLD_A || grasp_mode_reg == MODE_OFF)
                    begin
                        status_work_next = ST_SUPPRESSED;
                        state_next       = S_DONE;
                    end
                    else if (post_left_reg != '0)
                    begin
                        post_left_next   = post_left_reg - 1'b1;
                        status_work_next = ST_SKIPPED;
                        state_next       = S_DONE;
                    end
                    else
                    begin
                        if (frame_count_reg != '1)
                        begin
                            frame_count_next = frame_count_reg + 1'b1;
                        end
                        status_work_next = ST_EVAL;
                        finger_next      = '0;
                        state_next       = S_WRITE;
                    end
                end
            end
            S_WRITE:
            begin
                mem_wr_en                 = 1'b1;
                head_next[finger_reg]     = (head_cur == HEAD_W'(WINDOW_MAX - 1)) ?
                                            '0 : head_cur + 1'b1;
                fill_next[finger_reg]     = fill_new;
                cooldown_next[finger_reg] = cd_new;
                if (frame_count_reg >= startup_frames_reg && fill_new == len_eff
                    && cd_new == '0)
                begin
                    alu_op      = ALU_LOAD;
                    rd_idx_next = idx_dec(head_cur);
                    remain_next = len_eff - 1'b1;
                    state_next  = S_READ;
                end
                else if (last_finger)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    finger_next = finger_reg + 1'b1;
                end
            end
            S_READ:
            begin
                // reads issue back to back, data lands in the following cycle
                if (remain_reg != '0)
                begin
                    mem_rd_en    = 1'b1;
                    rd_idx_next  = idx_dec(rd_idx_reg);
                    remain_next  = remain_reg - 1'b1;
                    rd_pend_next = 1'b1;
                end
                if (rd_pend_reg)
                begin
                    alu_op = ALU_ACC;
                end
                // last sample folds in on the way out
                if (remain_reg == '0)
                begin
                    state_next = S_SCALE;
                end
            end
            S_SCALE:
            begin
                alu_op     = ALU_SCALE;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (alu_fire)
                begin
                    mask_work_next[finger_reg] = 1'b1;
                    cooldown_next[finger_reg]  = cooldown_frames_reg;
                end
                if (last_finger)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    finger_next = finger_reg + 1'b1;
                    state_next  = S_WRITE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next    = 1'b1;
                    release_mask_next = mask_work_reg;
                    status_next       = status_work_reg;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg     <= 4'd3;
            startup_frames_reg    <= 16'd20;
            cooldown_frames_reg   <= 8'd5;
            post_grasp_frames_reg <= '0;
            contact_thr_reg       <= CONTACT_THR_RST;
            delta_thr_reg         <= DELTA_THR_RST;
            spread_thr_reg        <= SPREAD_THR_RST;
            grasp_mode_reg        <= '0;
            post_left_reg         <= '0;
            frame_count_reg       <= '0;
            for (int f = 0; f < FINGERS; f++)
            begin
                fill_reg[f]     <= '0;
                head_reg[f]     <= '0;
                cooldown_reg[f] <= '0;
            end
            state_reg             <= S_IDLE;
            finger_reg            <= '0;
            rd_idx_reg            <= '0;
            remain_reg            <= '0;
            rd_pend_reg           <= 1'b0;
            mask_work_reg         <= '0;
            status_work_reg       <= ST_EVAL;
            out_valid_reg         <= 1'b0;
            release_mask_reg      <= '0;
            status_reg            <= ST_EVAL;
        end
        else
        begin
            window_length_reg     <= window_length_next;
            startup_frames_reg    <= startup_frames_next;
            cooldown_frames_reg   <= cooldown_frames_next;
            post_grasp_frames_reg <= post_grasp_frames_next;
            contact_thr_reg       <= contact_thr_next;
            delta_thr_reg         <= delta_thr_next;
            spread_thr_reg        <= spread_thr_next;
            grasp_mode_reg        <= grasp_mode_next;
            post_left_reg         <= post_left_next;
            frame_count_reg       <= frame_count_next;
            fill_reg              <= fill_next;
            head_reg              <= head_next;
            cooldown_reg          <= cooldown_next;
            state_reg             <= state_next;
            finger_reg            <= finger_next;
            rd_idx_reg            <= rd_idx_next;
            remain_reg            <= remain_next;
            rd_pend_reg           <= rd_pend_next;
            mask_work_reg         <= mask_work_next;
            status_work_reg       <= status_work_next;
            out_valid_reg         <= out_valid_next;
            release_mask_reg      <= release_mask_next;
            status_reg            <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            force_reg[0] <= force_thumb;
            force_reg[1] <= force_index;
            force_reg[2] <= force_middle;
            force_reg[3] <= force_ring;
            force_reg[4] <= force_little;
        end
    end

    tsrd_window_mem #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_window_mem (
        .clk     (clk),
        .finger  (finger_reg),
        .wr_en   (mem_wr_en),
        .wr_idx  (head_cur),
        .wr_data (force_reg[finger_reg]),
        .rd_en   (mem_rd_en),
        .rd_idx  (rd_idx_reg),
        .rd_data (mem_rdata)
    );

    tsrd_alu #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_alu (
        .clk  (clk),
        .op   (alu_op),
        .len  (len_eff),
        .x    (alu_x),
        .thr  (thr),
        .fire (alu_fire)
    );

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign release_mask = release_mask_reg;
    assign status       = status_reg;
    assign pready       = 1'b1;

endmodule

/* rtl/tsrd_checker.sv */
module tsrd_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic                          action,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [4:0]                    release_mask,
    input  logic [1:0]                    status
);
    import tsrd_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(release_mask) && $stable(status))
        else $error("result changed while stalled");

    // only an evaluated frame can flag fingers
    a_mask_eval_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_EVAL |-> release_mask == '0)
        else $error("release mask set on a frame that was not evaluated");

    // one request in flight: busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while previous one still in work");

    // a state update accepted with no result pending answers with an empty mask and its own status
    a_update_first_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && action == ACT_STATE && !out_valid |=> ##1
        out_valid && status == ST_UPDATE && release_mask == '0)
        else $error("state update did not report as such");

endmodule

bind tactile_slip_release_detector_unit tsrd_checker u_tsrd_checker (.*);
